FILE: sv/lkv_pkg.sv
// lkv_pkg: shared constants, codes and types of the lru key/value cache
// used by lkv_regs, lkv_engine and lru_key_value_cache; no dependencies
package lkv_pkg;

	// sizing of the cache
	localparam int ENTRIES    = 16;
	localparam int VALUE_BITS = 32;
	localparam int KEY_BITS   = 64;
	localparam int DATA_BITS  = 32;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int RANK_W     = IDX_W;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// capacity register
	localparam int CAP_BITS = 5;
	localparam int CMP_W    = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 1;
	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	// apb register map, one 32-bit word per register
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_CAP_IDX = 1'b0;

	// request kinds; any other code acts as a probe
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOAD   = 2'd1;
	localparam logic [1:0] KIND_PROBE  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// one stored row: key and value
	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] value;
	} request_t;

	typedef struct packed {
		logic                 hit;
		logic [DATA_BITS-1:0] value_out;
		logic                 evicted;
		logic [KEY_BITS-1:0]  evicted_key;
	} result_t;

endpackage

FILE: sv/lkv_ram.sv
// lkv_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
module lkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/lkv_regs.sv
// lkv_regs: apb configuration register of the cache (capacity in use)
// depends on lkv_pkg
module lkv_regs import lkv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	output logic [CAP_BITS-1:0] cap
);

	logic [CAP_BITS-1:0] cap_q;
	logic                wr_en;
	logic                sel_cap;

	assign pready  = 1'b1;
	assign sel_cap = (paddr[2] == REG_CAP_IDX);
	assign wr_en   = psel & penable & pwrite & pready;

	// capacity register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_en && sel_cap) begin
			cap_q <= pwdata[CAP_BITS-1:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (sel_cap) begin
			prdata = PDATA_W'(cap_q);
		end
	end

	assign cap = cap_q;

endmodule

FILE: sv/lkv_engine.sv
// lkv_engine: lookup sequencer of the cache; scans the key/value ram one row
// a cycle, holds valid bits and recency ranks, commits and registers result
// depends on lkv_pkg
module lkv_engine import lkv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  request_t            req,
	input  logic [CAP_BITS-1:0] cap,
	output logic [IDX_W-1:0]    ram_raddr,
	input  entry_t              ram_rdata,
	output logic                ram_we,
	output logic [IDX_W-1:0]    ram_waddr,
	output entry_t              ram_wdata,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res
);

	state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;

	// captured request
	request_t req_q;

	// scan trackers
	logic                  match_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic [VALUE_BITS-1:0] match_val_q;
	logic [RANK_W-1:0]     match_rank_q;
	logic                  vic_found_q;
	logic [IDX_W-1:0]      vic_idx_q;
	logic [RANK_W-1:0]     vic_rank_q;
	logic [KEY_BITS-1:0]   vic_key_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;

	// per-entry state
	logic [ENTRIES-1:0] valid_q;
	logic [RANK_W-1:0]  rank_q [ENTRIES];
	logic [CNT_W-1:0]   filled_q;

	// result register
	logic    out_valid_q;
	result_t out_q;

	// commit decisions
	logic                accept;
	logic                commit_go;
	logic                cur_valid;
	logic [RANK_W-1:0]   cur_rank;
	logic                fill_ok;
	logic [CMP_W-1:0]    cap_lim;
	logic                do_fill;
	logic                do_evict;
	logic                do_touch;
	logic                age_all;
	logic                set_valid;
	logic [IDX_W-1:0]    tgt_idx;
	logic [RANK_W-1:0]   thr;
	result_t             res_d;

	assign accept    = req_valid & req_ready;
	assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || res_ready);
	assign cur_valid = valid_q[cnt_q];
	assign cur_rank  = rank_q[cnt_q];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (commit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// read address: row 0 issued on accept, then one row ahead of the compare
	always_comb begin
		ram_raddr = '0;
		if (state_q == ST_SCAN && cnt_q != LAST_IDX) begin
			ram_raddr = cnt_q + 1'b1;
		end
	end

	// scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// request capture and scan trackers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= req;
			match_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (cur_valid && !match_q && ram_rdata.key == req_q.key) begin
				match_q      <= 1'b1;
				match_idx_q  <= cnt_q;
				match_val_q  <= ram_rdata.value;
				match_rank_q <= cur_rank;
			end
			if (cur_valid && (!vic_found_q || cur_rank > vic_rank_q)) begin
				vic_found_q <= 1'b1;
				vic_idx_q   <= cnt_q;
				vic_rank_q  <= cur_rank;
				vic_key_q   <= ram_rdata.key;
			end
			if (!cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= cnt_q;
			end
		end
	end

	// effective capacity: zero acts as one, clamped to the entry count
	always_comb begin
		cap_lim = CMP_W'(cap);
		if (CMP_W'(cap) > CMP_W'(ENTRIES)) begin
			cap_lim = CMP_W'(ENTRIES);
		end
		fill_ok = (filled_q == '0) || (CMP_W'(filled_q) < cap_lim);
	end

	// commit decision and result
	always_comb begin
		do_fill   = 1'b0;
		do_evict  = 1'b0;
		do_touch  = 1'b0;
		age_all   = 1'b0;
		set_valid = 1'b0;
		tgt_idx   = match_idx_q;
		thr       = match_rank_q;
		ram_we    = 1'b0;
		ram_waddr = match_idx_q;
		ram_wdata.key   = req_q.key;
		ram_wdata.value = VALUE_BITS'(req_q.value);
		res_d.hit         = match_q;
		res_d.value_out   = '0;
		res_d.evicted     = 1'b0;
		res_d.evicted_key = '0;
		case (req_q.kind)
			KIND_INSERT: begin
				if (match_q) begin
					do_touch = 1'b1;
					ram_we   = 1'b1;
				end else if (fill_ok) begin
					do_fill   = free_found_q;
					ram_we    = free_found_q;
					ram_waddr = free_idx_q;
				end else begin
					do_evict  = vic_found_q;
					ram_we    = vic_found_q;
					ram_waddr = vic_idx_q;
				end
			end
			KIND_LOAD: begin
				if (match_q) begin
					do_touch        = 1'b1;
					res_d.value_out = DATA_BITS'(match_val_q);
				end
			end
			default: begin
			end
		endcase
		if (do_fill) begin
			age_all   = 1'b1;
			set_valid = 1'b1;
			tgt_idx   = free_idx_q;
		end
		if (do_evict) begin
			age_all           = 1'b1;
			tgt_idx           = vic_idx_q;
			res_d.evicted     = 1'b1;
			res_d.evicted_key = vic_key_q;
		end
		ram_we = ram_we & commit_go;
	end

	// valid bits, recency ranks and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			filled_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (commit_go && (do_fill || do_evict || do_touch)) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == tgt_idx) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (age_all || rank_q[i] < thr)) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (set_valid) begin
				valid_q[tgt_idx] <= 1'b1;
				filled_q         <= filled_q + 1'b1;
			end
		end
	end

	// result register, frees as soon as the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_go) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			out_q <= res_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

FILE: sv/lru_key_value_cache.sv
// lru_key_value_cache: top level of the fully associative lru key/value cache
// depends on lkv_pkg, lkv_ram, lkv_regs and lkv_engine
//
// Each request (insert, load or probe) is scanned over every row before its
// result is registered. The read of row 0 is issued in the transfer cycle.
// Then each stored row is read in turn through the single read port of the
// key/value ram and compared. Last comes the commit state, which writes the
// ram and updates the valid bits and recency ranks. The cache is ready again
// in the idle cycle after the commit, so it takes no new request while one is
// still in flight. A result waits in the output register while the next
// request is scanned. A commit stalls only while the previous result is still
// unread. Keys and values live in the ram and are defined only once written.
// Valid bits and ranks are cleared by reset, so no clearing pass is needed.
// capacity_in_use is written over apb at byte address 0; the user must write
// it only while the cache is idle, as the block does not enforce this.
module lru_key_value_cache import lkv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// request stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [95:0]         s_tdata,  // lookup_key [63:0], value_in [95:64]
	input  logic [1:0]          s_tuser,  // kind [1:0]
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [95:0]         m_tdata,  // value_out [31:0], evicted_key [95:32]
	output logic [1:0]          m_tuser,  // hit [0], evicted [1]
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	request_t            req;
	result_t             res;
	logic [CAP_BITS-1:0] cap;
	logic [IDX_W-1:0]    ram_raddr;
	logic [IDX_W-1:0]    ram_waddr;
	logic                ram_we;
	entry_t              ram_rdata;
	entry_t              ram_wdata;

	// unpack request transfer
	assign req.kind  = s_tuser;
	assign req.key   = s_tdata[63:0];
	assign req.value = s_tdata[95:64];

	// pack result transfer
	assign m_tdata = {res.evicted_key, res.value_out};
	assign m_tuser = {res.evicted, res.hit};

	lkv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap     (cap)
	);

	lkv_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lkv_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.cap       (cap),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// one request at a time: no new transfer right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous one still in flight");

	// an eviction only happens on an insert miss
	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> !m_tuser[0])
		else $error("eviction reported together with a hit");

	// a value is returned only for a hit
	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == '0))
		else $error("nonzero value on a miss");

	// evicted key is zero unless an entry was evicted
	a_key_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[95:32] == '0))
		else $error("evicted key without eviction");

endmodule

FILE: dv/lkv_checker.sv
// lkv_checker: watches the request, result and apb channels of lru_key_value_cache,
// predicts each result from its own copy of the cache state and compares it
// depends on lkv_pkg
module lkv_checker import lkv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [95:0]        s_tdata,  // lookup_key [63:0], value_in [95:64]
	input  logic [1:0]         s_tuser,  // kind [1:0]
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [95:0]        m_tdata,  // value_out [31:0], evicted_key [95:32]
	input  logic [1:0]         m_tuser,  // hit [0], evicted [1]
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the cache
	logic [KEY_BITS-1:0]   row_key   [ENTRIES];
	logic [VALUE_BITS-1:0] row_val   [ENTRIES];
	logic                  row_valid [ENTRIES];
	logic [RANK_W-1:0]     row_rank  [ENTRIES];
	logic [CNT_W-1:0]      row_count;
	logic [CAP_BITS-1:0]   cap_reg;

	// results still owed by the cache, oldest first
	result_t owed_results[$];

	// make row e the most recent; rows more recent than it age by one
	function automatic void promote(int e);
		logic [RANK_W-1:0] old_rank;
		old_rank = row_rank[e];
		for (int i = 0; i < ENTRIES; i++)
			if (row_valid[i] && i != e && row_rank[i] < old_rank)
				row_rank[i]++;
		row_rank[e] = '0;
	endfunction

	// place a new row in free slot e; every held row ages by one
	function automatic void admit(int e, logic [KEY_BITS-1:0] key,
			logic [VALUE_BITS-1:0] value);
		for (int i = 0; i < ENTRIES; i++)
			if (row_valid[i])
				row_rank[i]++;
		row_key[e]   = key;
		row_val[e]   = value;
		row_valid[e] = 1'b1;
		row_rank[e]  = '0;
	endfunction

	// apply one request to the shadow cache and return its result
	function automatic result_t predict_access(logic [1:0] kind,
			logic [KEY_BITS-1:0] key, logic [DATA_BITS-1:0] value);
		result_t r;
		int found;
		int slot;
		int victim;
		int limit;
		r = '0;
		found = -1;
		slot = -1;
		victim = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && row_valid[i] && row_key[i] == key)
				found = i;
		// zero acts as one, oversize acts as full size
		limit = (cap_reg == 0) ? 1 : (int'(cap_reg) > ENTRIES) ? ENTRIES : int'(cap_reg);
		r.hit = (found >= 0);
		if (kind == KIND_INSERT) begin
			if (found >= 0) begin
				row_val[found] = value[VALUE_BITS-1:0];
				promote(found);
			end else if (int'(row_count) < limit || row_count == 0) begin
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!row_valid[i])
						slot = i;
				if (slot >= 0) begin
					admit(slot, key, value[VALUE_BITS-1:0]);
					row_count++;
				end
			end else begin
				// least recent row holds the largest rank
				for (int i = 0; i < ENTRIES; i++)
					if (row_valid[i] && (victim < 0 || row_rank[i] > row_rank[victim]))
						victim = i;
				if (victim >= 0) begin
					r.evicted     = 1'b1;
					r.evicted_key = row_key[victim];
					row_valid[victim] = 1'b0;
					admit(victim, key, value[VALUE_BITS-1:0]);
				end
			end
		end else if (kind == KIND_LOAD) begin
			if (found >= 0) begin
				r.value_out = DATA_BITS'(row_val[found]);
				promote(found);
			end
		end
		return r;
	endfunction

	// channel monitor
	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		result_t got;
		int fails;
		fails = 0;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				row_key[i]   = '0;
				row_val[i]   = '0;
				row_valid[i] = 1'b0;
				row_rank[i]  = '0;
			end
			row_count = '0;
			cap_reg = CAP_RESET;
			owed_results.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// result transfer against the oldest owed result
			if (m_tvalid && m_tready) begin
				got.hit         = m_tuser[0];
				got.evicted     = m_tuser[1];
				got.value_out   = m_tdata[31:0];
				got.evicted_key = m_tdata[95:32];
				if (owed_results.size() == 0) begin
					$display("%t: unexpected result hit=%0d value=%h evicted=%0d key=%h",
						$time, got.hit, got.value_out, got.evicted, got.evicted_key);
					fails++;
				end else begin
					want = owed_results.pop_front();
					if (got.hit !== want.hit || got.value_out !== want.value_out ||
							got.evicted !== want.evicted ||
							got.evicted_key !== want.evicted_key) begin
						$display("%t: result mismatch, expected hit=%0d value=%h evicted=%0d key=%h",
							$time, want.hit, want.value_out, want.evicted, want.evicted_key);
						$display("%t:                  actual hit=%0d value=%h evicted=%0d key=%h",
							$time, got.hit, got.value_out, got.evicted, got.evicted_key);
						fails++;
					end
				end
			end
			// request transfer
			if (s_tvalid && s_tready)
				owed_results.push_back(predict_access(s_tuser, s_tdata[63:0], s_tdata[95:64]));
			// register access
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_CAP_IDX) begin
				if (pwrite) begin
					cap_reg = pwdata[CAP_BITS-1:0];
				end else if (prdata !== PDATA_W'(cap_reg)) begin
					$display("%t: capacity readback mismatch, expected %h actual %h",
						$time, PDATA_W'(cap_reg), prdata);
					fails++;
				end
			end
			errors <= errors + fails;
			pending <= owed_results.size();
		end
	end

endmodule

FILE: dv/tb_lru_key_value_cache.sv
// tb_lru_key_value_cache: drives requests, results backpressure and capacity writes
// into lru_key_value_cache; checking is done by lkv_checker
// depends on lkv_pkg, lru_key_value_cache and lkv_checker
module tb_lru_key_value_cache import lkv_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_SPARE = 2'd3;  // unused code, behaves as a probe
	localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAP_IDX, 2'b00};
	localparam int POOL = 32;
	localparam int PHASE_ITEMS = 95;
	localparam int TAIL_CYCLES = 2 * (ENTRIES + 2);
	localparam int CYCLE_LIMIT = 250000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [95:0]        s_tdata;  // lookup_key [63:0], value_in [95:64]
	logic [1:0]         s_tuser;  // kind [1:0]
	logic               m_tvalid;
	logic               m_tready;
	logic [95:0]        m_tdata;  // value_out [31:0], evicted_key [95:32]
	logic [1:0]         m_tuser;  // hit [0], evicted [1]
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int errors;
	int pending;
	int cycle_count = 0;
	bit calm = 1'b0;  // no idling on either side while set
	logic [KEY_BITS-1:0] key_pool [POOL];

	lru_key_value_cache dut (.*);

	lkv_checker checker_i (.*);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lru_key_value_cache regression: fail");
			$finish;
		end
	end

	// result side backpressure
	always @(posedge clk)
		m_tready <= arst_n && (calm || $urandom_range(0, 99) >= 13);

	// one request transfer, with random gaps ahead of it
	task automatic send_request(input logic [1:0] kind, input logic [KEY_BITS-1:0] key,
			input logic [DATA_BITS-1:0] value);
		while (!calm && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom, $urandom};
			s_tuser <= 2'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {value, key};
		s_tuser <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop sending and wait for every owed result
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// capacity write followed by a readback, psel held across both
	task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= ($urandom << CAP_BITS) | PDATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// random requests over a key span sized around the capacity
	task automatic run_phase(input int count, input int span);
		logic [1:0] kind;
		logic [KEY_BITS-1:0] key;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			kind = (pick < 40) ? KIND_INSERT : (pick < 75) ? KIND_LOAD :
				(pick < 94) ? KIND_PROBE : KIND_SPARE;
			if ($urandom_range(0, 9) == 0)
				key = {$urandom, $urandom};
			else
				key = key_pool[$urandom_range(0, span - 1)];
			send_request(kind, key, $urandom);
		end
		drain();
	endtask

	initial begin : stimulus
		int caps [13];
		int eff;
		caps = '{16, 1, 17, 8, 3, 31, 12, 2, 0, 15, 5, 24, 16};
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_INSERT;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// capacity zero acting as one, starting from an empty cache
		set_capacity(0);
		send_request(KIND_LOAD, key_pool[0], $urandom);
		send_request(KIND_PROBE, key_pool[0], $urandom);
		send_request(KIND_INSERT, key_pool[0], 32'h0000_0000);
		send_request(KIND_INSERT, key_pool[1], 32'hffff_ffff);
		send_request(KIND_LOAD, key_pool[1], $urandom);
		send_request(KIND_SPARE, key_pool[1], $urandom);
		send_request(KIND_INSERT, key_pool[1], 32'h5a5a_a5a5);
		send_request(KIND_PROBE, key_pool[0], $urandom);
		drain();

		// oversize capacity, plain fills and hits
		set_capacity(31);
		for (int i = 2; i < 6; i++)
			send_request(KIND_INSERT, key_pool[i], $urandom);
		send_request(KIND_LOAD, key_pool[3], $urandom);
		send_request(KIND_PROBE, key_pool[2], $urandom);
		send_request(KIND_LOAD, key_pool[6], $urandom);
		drain();

		// capacity lowered below the fill
		set_capacity(2);
		send_request(KIND_INSERT, key_pool[7], $urandom);
		send_request(KIND_INSERT, key_pool[8], $urandom);
		send_request(KIND_LOAD, key_pool[3], $urandom);
		send_request(KIND_INSERT, key_pool[8], $urandom);
		send_request(KIND_LOAD, key_pool[8], $urandom);
		drain();

		// random phases across capacity settings
		foreach (caps[p]) begin
			eff = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
			calm = (p == 5);
			set_capacity(CAP_BITS'(caps[p]));
			run_phase(PHASE_ITEMS, eff + $urandom_range(1, 4));
		end
		calm = 1'b0;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("lru_key_value_cache regression: pass");
		else
			$display("lru_key_value_cache regression: fail");
		$finish;
	end

endmodule

FILE: lru_key_value_cache.f
sv/lkv_pkg.sv
sv/lkv_ram.sv
sv/lkv_regs.sv
sv/lkv_engine.sv
sv/lru_key_value_cache.sv
dv/lkv_checker.sv
dv/tb_lru_key_value_cache.sv
